// ----- rtl/ppurp_pkg.sv -----
// Shared codes and types for the video processor register port.
// No dependencies; used by ppurp_mem and ppu_register_port_vram.
package ppurp_pkg;

    // func codes
    localparam logic [2:0] FN_READ      = 3'd0;
    localparam logic [2:0] FN_WRITE     = 3'd1;
    localparam logic [2:0] FN_VBLANK    = 3'd2;
    localparam logic [2:0] FN_PRERENDER = 3'd3;
    localparam logic [2:0] FN_SPR0_HIT  = 3'd4;
    localparam logic [2:0] FN_SPR_OVF   = 3'd5;

    // register indices
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // nametable mirroring
    localparam logic [2:0] MIR_VERT = 3'd0;
    localparam logic [2:0] MIR_HORZ = 3'd1;
    localparam logic [2:0] MIR_LOW  = 3'd2;
    localparam logic [2:0] MIR_HIGH = 3'd3;
    localparam logic [2:0] MIR_FOUR = 3'd4;

    // VRAM map
    localparam int          PAT_AW      = 13;
    localparam logic [13:0] VPAL_BASE   = 14'h3F00;
    localparam logic [13:0] VPAL_NT_OFS = 14'h1000;

    typedef struct packed {
        logic       vram_we;
        logic       spr_we;
        logic [7:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic [7:0] vram;
        logic [7:0] nt;
        logic [7:0] spr;
        logic       is_pal;
    } t_mem_rd;

endpackage

// ----- rtl/ppu_register_port_vram.sv -----
// Top level: CPU register port of the tile video processor.
// Uses ppurp_pkg and ppurp_mem (video and sprite memories).
//
//  channel   | signals                                        | transfer
//  ----------+------------------------------------------------+----------------------------
//  command   | start, busy, i_func, i_reg_req, i_wdata, i_peek | start && !busy
//  result    | o_strobe, o_rdata, o_nmi_request                | every cycle o_strobe is high
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_data            | i_cfg_valid && o_cfg_ready
//
// The accept edge registers the memory reads at the current addresses; in the
// execute phase (r_exec) the registers are updated and the memories written.
// o_strobe is high in the cycle after that; a new command may be accepted then.
// After reset a clearing pass over the pattern RAM depth (8192 entries) holds busy high.
// Results cannot be stalled; configuration is always ready.
module ppu_register_port_vram #(
    parameter int NAMETABLE_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_func,
    input  logic [2:0] i_reg_req,
    input  logic [7:0] i_wdata,
    input  logic       i_peek,
    output logic       o_strobe,
    output logic [7:0] o_rdata,
    output logic       o_nmi_request,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);

    logic [2:0]  r_mirror;
    logic        r_exec;
    logic [2:0]  r_func, r_reg;
    logic [7:0]  r_wdata;
    logic        r_peek;
    logic        r_strobe, r_nmi;

    logic [13:0] r_vram_addr, n_vram_addr;
    logic [14:0] r_temp_addr, n_temp_addr;
    logic [2:0]  r_fine_x, n_fine_x;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_spr_addr, n_spr_addr;
    logic [7:0]  r_rd_buf, n_rd_buf;
    logic [7:0]  r_bus_latch, n_bus_latch;
    logic [2:0]  r_status, n_status;
    logic        r_nmi_prev, n_nmi_prev;
    logic        n_nmi;

    ppurp_pkg::t_mem_wr mem_wr;
    ppurp_pkg::t_mem_rd mem_rd;
    logic               clr_busy;
    logic               accept;

    ppurp_mem #(
        .NT_BYTES (NAMETABLE_BYTES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mirror   (r_mirror),
        .i_vaddr    (r_vram_addr),
        .i_saddr    (r_spr_addr),
        .i_wr       (mem_wr),
        .o_rd       (mem_rd),
        .o_clr_busy (clr_busy)
    );

    assign busy        = r_exec || clr_busy;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign mem_wr.vram_we = r_exec && (r_func == ppurp_pkg::FN_WRITE)
                            && (r_reg == ppurp_pkg::REG_DATA);
    assign mem_wr.spr_we  = r_exec && (r_func == ppurp_pkg::FN_WRITE)
                            && (r_reg == ppurp_pkg::REG_OAM_DATA);
    assign mem_wr.data    = r_wdata;

    logic [13:0] vram_inc;
    logic        ctrl_out;
    assign vram_inc = r_ctrl[2] ? 14'd32 : 14'd1;
    assign ctrl_out = r_status[2] && r_wdata[7];

    always_comb begin
        n_vram_addr = r_vram_addr;
        n_temp_addr = r_temp_addr;
        n_fine_x    = r_fine_x;
        n_toggle    = r_toggle;
        n_ctrl      = r_ctrl;
        n_spr_addr  = r_spr_addr;
        n_rd_buf    = r_rd_buf;
        n_bus_latch = r_bus_latch;
        n_status    = r_status;
        n_nmi_prev  = r_nmi_prev;
        n_nmi       = 1'b0;
        case (r_func)
            ppurp_pkg::FN_READ: begin
                case (r_reg)
                    ppurp_pkg::REG_STATUS: begin
                        n_bus_latch = {r_status, r_bus_latch[4:0]};
                        if (!r_peek) begin
                            n_status[2] = 1'b0;
                            n_toggle    = 1'b0;
                        end
                    end
                    ppurp_pkg::REG_OAM_DATA: n_bus_latch = mem_rd.spr;
                    ppurp_pkg::REG_DATA: begin
                        if (mem_rd.is_pal) begin
                            n_bus_latch = mem_rd.vram;
                            n_rd_buf    = mem_rd.nt;
                        end else begin
                            n_bus_latch = r_rd_buf;
                            n_rd_buf    = mem_rd.vram;
                        end
                        n_vram_addr = 14'(r_vram_addr + vram_inc);
                    end
                    default: ;
                endcase
            end
            ppurp_pkg::FN_WRITE: begin
                n_bus_latch = r_wdata;
                case (r_reg)
                    ppurp_pkg::REG_CTRL: begin
                        n_ctrl      = r_wdata;
                        n_temp_addr = {r_temp_addr[14:12], r_wdata[1:0], r_temp_addr[9:0]};
                        n_nmi       = !r_nmi_prev && !r_ctrl[7] && ctrl_out;
                        n_nmi_prev  = ctrl_out;
                    end
                    ppurp_pkg::REG_OAM_ADDR: n_spr_addr = r_wdata;
                    ppurp_pkg::REG_OAM_DATA: n_spr_addr = r_spr_addr + 8'd1;
                    ppurp_pkg::REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_fine_x    = r_wdata[2:0];
                            n_temp_addr = {r_temp_addr[14:5], r_wdata[7:3]};
                            n_toggle    = 1'b1;
                        end else begin
                            n_temp_addr = {r_wdata[2:0], r_temp_addr[11:10], r_wdata[7:3],
                                           r_temp_addr[4:0]};
                            n_toggle    = 1'b0;
                        end
                    end
                    ppurp_pkg::REG_ADDR: begin
                        if (!r_toggle) begin
                            n_temp_addr = {1'b0, r_wdata[5:0], r_temp_addr[7:0]};
                            n_toggle    = 1'b1;
                        end else begin
                            n_temp_addr = {r_temp_addr[14:8], r_wdata};
                            n_vram_addr = {r_temp_addr[13:8], r_wdata};
                            n_toggle    = 1'b0;
                        end
                    end
                    ppurp_pkg::REG_DATA: n_vram_addr = 14'(r_vram_addr + vram_inc);
                    default: ;
                endcase
            end
            ppurp_pkg::FN_VBLANK: begin
                n_nmi       = !r_status[2] && r_ctrl[7];
                n_status[2] = 1'b1;
            end
            ppurp_pkg::FN_PRERENDER: n_status    = 3'b000;
            ppurp_pkg::FN_SPR0_HIT:  n_status[1] = 1'b1;
            ppurp_pkg::FN_SPR_OVF:   n_status[0] = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_reg   <= i_reg_req;
            r_wdata <= i_wdata;
            r_peek  <= i_peek;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror    <= ppurp_pkg::MIR_VERT;
            r_exec      <= 1'b0;
            r_strobe    <= 1'b0;
            r_nmi       <= 1'b0;
            r_vram_addr <= '0;
            r_temp_addr <= '0;
            r_fine_x    <= '0;
            r_toggle    <= 1'b0;
            r_ctrl      <= '0;
            r_spr_addr  <= '0;
            r_rd_buf    <= '0;
            r_bus_latch <= '0;
            r_status    <= '0;
            r_nmi_prev  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mirror <= i_cfg_data;
            end
            r_exec   <= accept;
            r_strobe <= r_exec;
            r_nmi    <= r_exec && n_nmi;
            if (r_exec) begin
                r_vram_addr <= n_vram_addr;
                r_temp_addr <= n_temp_addr;
                r_fine_x    <= n_fine_x;
                r_toggle    <= n_toggle;
                r_ctrl      <= n_ctrl;
                r_spr_addr  <= n_spr_addr;
                r_rd_buf    <= n_rd_buf;
                r_bus_latch <= n_bus_latch;
                r_status    <= n_status;
                r_nmi_prev  <= n_nmi_prev;
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_rdata       = r_bus_latch;
    assign o_nmi_request = r_nmi;

    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exec |=> !r_exec)
        else $error("execute phase lasted more than one cycle");

    a_strobe_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exec |=> r_strobe)
        else $error("result strobe missing after execute");

    a_nmi_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nmi |-> r_strobe)
        else $error("nmi request without a result");

    a_no_exec_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !r_exec)
        else $error("command executed during clearing pass");

    a_vaddr_moves_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_vram_addr)) |-> $past(r_exec))
        else $error("VRAM address changed outside execute");

endmodule

// ----- rtl/ppurp_mem.sv -----
// Pattern, nametable, palette and sprite memories with address mapping,
// registered reads and the post-reset clearing pass. Uses ppurp_pkg.
module ppurp_mem #(
    parameter int NT_BYTES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_mirror,
    input  logic [13:0]         i_vaddr,
    input  logic [7:0]          i_saddr,
    input  ppurp_pkg::t_mem_wr  i_wr,
    output ppurp_pkg::t_mem_rd  o_rd,
    output logic                o_clr_busy
);

    localparam int NT_AW  = $clog2(NT_BYTES);
    localparam int PAT_AW = ppurp_pkg::PAT_AW;

    logic [7:0] pat_mem [2**PAT_AW];
    logic [7:0] nt_mem  [NT_BYTES];
    logic [7:0] pal_mem [32];
    logic [7:0] spr_mem [256];

    logic [PAT_AW-1:0] r_clr_cnt;
    logic              r_clr_busy;

    logic [7:0] r_pat_q, r_nt_q, r_pal_q, r_spr_q;
    logic       r_nt_ok, r_pat_sel, r_pal_sel;

    // {mapped, page, offset}
    function automatic logic [12:0] nt_map(input logic [13:0] a, input logic [2:0] mode);
        logic [1:0] quad;
        logic [1:0] page;
        logic       ok;
        quad = a[11:10];
        page = 2'd0;
        ok   = 1'b1;
        unique case (mode)
            ppurp_pkg::MIR_VERT: page = {1'b0, quad[0]};
            ppurp_pkg::MIR_HORZ: page = {1'b0, quad[1]};
            ppurp_pkg::MIR_LOW:  page = 2'd0;
            ppurp_pkg::MIR_HIGH: page = 2'd1;
            ppurp_pkg::MIR_FOUR: page = quad;
            default:             ok = 1'b0;
        endcase
        return {ok, page, a[9:0]};
    endfunction

    // raw < 4096, below 2*NT_BYTES when NT_BYTES >= 2048, so one compare and subtract
    function automatic logic [NT_AW-1:0] nt_wrap(input logic [11:0] raw);
        logic [12:0] w;
        w = {1'b0, raw};
        if (w >= 13'(NT_BYTES)) begin
            w = w - 13'(NT_BYTES);
        end
        return w[NT_AW-1:0];
    endfunction

    // backdrop entries 10/14/18/1C alias to 00/04/08/0C
    function automatic logic [4:0] pal_idx(input logic [13:0] a);
        logic [4:0] p;
        p = a[4:0];
        if (p[4] && (p[1:0] == 2'b00)) begin
            p[4] = 1'b0;
        end
        return p;
    endfunction

    logic        is_pat, is_pal;
    logic [13:0] nt_ra;
    logic [12:0] map_r, map_w;

    assign is_pat = !i_vaddr[13];
    assign is_pal = (i_vaddr >= ppurp_pkg::VPAL_BASE);
    assign nt_ra  = is_pal ? 14'(i_vaddr - ppurp_pkg::VPAL_NT_OFS) : i_vaddr;
    assign map_r  = nt_map(nt_ra, i_mirror);
    assign map_w  = nt_map(i_vaddr, i_mirror);

    // write ports, shared with the clearing pass
    logic              pat_we, nt_we, pal_we, spr_we;
    logic [PAT_AW-1:0] pat_wa;
    logic [NT_AW-1:0]  nt_wa;
    logic [4:0]        pal_wa;
    logic [7:0]        spr_wa, vram_wd, spr_wd;

    always_comb begin
        if (r_clr_busy) begin
            pat_we  = 1'b1;
            nt_we   = ({1'b0, r_clr_cnt} < (PAT_AW+1)'(NT_BYTES));
            pal_we  = 1'b1;
            spr_we  = 1'b1;
            pat_wa  = r_clr_cnt;
            nt_wa   = r_clr_cnt[NT_AW-1:0];
            pal_wa  = r_clr_cnt[4:0];
            spr_wa  = r_clr_cnt[7:0];
            vram_wd = 8'h00;
            spr_wd  = 8'hFF;
        end else begin
            pat_we  = i_wr.vram_we && is_pat;
            nt_we   = i_wr.vram_we && !is_pat && !is_pal && map_w[12];
            pal_we  = i_wr.vram_we && is_pal;
            spr_we  = i_wr.spr_we;
            pat_wa  = i_vaddr[PAT_AW-1:0];
            nt_wa   = nt_wrap(map_w[11:0]);
            pal_wa  = pal_idx(i_vaddr);
            spr_wa  = i_saddr;
            vram_wd = i_wr.data;
            spr_wd  = i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            pat_mem[pat_wa] <= vram_wd;
        end
        r_pat_q <= pat_mem[i_vaddr[PAT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (nt_we) begin
            nt_mem[nt_wa] <= vram_wd;
        end
        r_nt_q <= nt_mem[nt_wrap(map_r[11:0])];
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            pal_mem[pal_wa] <= vram_wd;
        end
        r_pal_q <= pal_mem[pal_idx(i_vaddr)];
    end

    always_ff @(posedge i_clk) begin
        if (spr_we) begin
            spr_mem[spr_wa] <= spr_wd;
        end
        r_spr_q <= spr_mem[i_saddr];
    end

    always_ff @(posedge i_clk) begin
        r_nt_ok   <= map_r[12];
        r_pat_sel <= is_pat;
        r_pal_sel <= is_pal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (&r_clr_cnt) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    logic [7:0] nt_v;
    assign nt_v = r_nt_ok ? r_nt_q : 8'h00;

    assign o_rd.vram   = r_pat_sel ? r_pat_q : (r_pal_sel ? r_pal_q : nt_v);
    assign o_rd.nt     = nt_v;
    assign o_rd.spr    = r_spr_q;
    assign o_rd.is_pal = r_pal_sel;
    assign o_clr_busy  = r_clr_busy;

endmodule

// ----- tb/tb_ppu_register_port_vram.sv -----
// Self-checking testbench for ppu_register_port_vram: directed then random register
// accesses and renderer events, checked against a cycle-free predictor of the port.
// Depends on ppurp_pkg and the RTL of ppu_register_port_vram.
`timescale 1ns / 1ps

module tb_ppu_register_port_vram;

    localparam int          NT_BYTES      = 4096;
    localparam int          PHASE_ITEMS   = 150;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam logic [2:0]  FN_SPARE6     = 3'd6;
    localparam logic [2:0]  FN_SPARE7     = 3'd7;
    localparam logic [2:0]  MIR_SPARE5    = 3'd5;
    localparam logic [2:0]  MIR_SPARE6    = 3'd6;
    localparam logic [2:0]  MIR_SPARE7    = 3'd7;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] reg_sel;
        logic [7:0] wdata;
        logic       peek;
    } t_ppu_cmd;

    typedef struct packed {
        logic [7:0] rdata;
        logic       nmi_request;
    } t_ppu_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       start     = 1'b0;
    logic       busy;
    logic [2:0] i_func    = ppurp_pkg::FN_READ;
    logic [2:0] i_reg_req = ppurp_pkg::REG_CTRL;
    logic [7:0] i_wdata   = 8'h00;
    logic       i_peek    = 1'b0;
    logic       o_strobe;
    logic [7:0] o_rdata;
    logic       o_nmi_request;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_data;

    ppu_register_port_vram #(
        .NAMETABLE_BYTES(NT_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_reg_req    (i_reg_req),
        .i_wdata      (i_wdata),
        .i_peek       (i_peek),
        .o_strobe     (o_strobe),
        .o_rdata      (o_rdata),
        .o_nmi_request(o_nmi_request),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    t_ppu_cmd    cmd_pending_q[$];
    t_ppu_result port_results_q[$];
    int          cmds_queued;
    int          errors;
    int          gap_pct;
    int          cycle_count;
    bit          cmd_taken;

    // predicted port state
    logic [2:0]  mirror_m;
    logic [13:0] vaddr_m;
    logic [14:0] temp_m;
    logic [2:0]  fine_x_m;
    logic        toggle_m;
    logic [7:0]  ctrl_m;
    logic [7:0]  oam_addr_m;
    logic [7:0]  read_buf_m;
    logic [7:0]  bus_latch_m;
    logic [2:0]  status_m;
    logic        nmi_prev_m;
    logic [7:0]  spr_m [256];
    logic [7:0]  pal_m [32];
    logic [7:0]  nt_m  [NT_BYTES];
    logic [7:0]  pat_m [8192];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int nt_slot(input logic [13:0] a);
        logic [1:0] quad;
        int         page;
        quad = a[11:10];
        case (mirror_m)
            ppurp_pkg::MIR_VERT: page = quad[0];
            ppurp_pkg::MIR_HORZ: page = quad[1];
            ppurp_pkg::MIR_LOW:  page = 0;
            ppurp_pkg::MIR_HIGH: page = 1;
            ppurp_pkg::MIR_FOUR: page = quad;
            default:             return -1;
        endcase
        return ((page << 10) | a[9:0]) % NT_BYTES;
    endfunction

    function automatic logic [4:0] pal_slot(input logic [13:0] a);
        logic [4:0] p;
        p = a[4:0];
        if ((p & 5'h13) == 5'h10) p = p & 5'h0F;
        return p;
    endfunction

    function automatic logic [7:0] vram_rd(input logic [13:0] a);
        int i;
        if (a < 14'h2000) return pat_m[a[12:0]];
        if (a < ppurp_pkg::VPAL_BASE) begin
            i = nt_slot(a);
            return (i < 0) ? 8'h00 : nt_m[i];
        end
        return pal_m[pal_slot(a)];
    endfunction

    task automatic vram_wr(input logic [13:0] a, input logic [7:0] d);
        int i;
        if (a < 14'h2000) begin
            pat_m[a[12:0]] = d;
        end else if (a < ppurp_pkg::VPAL_BASE) begin
            i = nt_slot(a);
            if (i >= 0) nt_m[i] = d;
        end else begin
            pal_m[pal_slot(a)] = d;
        end
    endtask

    task automatic step_vaddr();
        vaddr_m = vaddr_m + (ctrl_m[2] ? 14'd32 : 14'd1);
    endtask

    task automatic ppu_port_access(input t_ppu_cmd c, output t_ppu_result r);
        logic [13:0] a;
        logic [7:0]  v;
        logic        was_en;
        logic        outp;
        r.nmi_request = 1'b0;
        case (c.func)
            ppurp_pkg::FN_READ: begin
                case (c.reg_sel)
                    ppurp_pkg::REG_STATUS: begin
                        bus_latch_m = {status_m, bus_latch_m[4:0]};
                        if (!c.peek) begin
                            status_m[2] = 1'b0;
                            toggle_m = 1'b0;
                        end
                    end
                    ppurp_pkg::REG_OAM_DATA: bus_latch_m = spr_m[oam_addr_m];
                    ppurp_pkg::REG_DATA: begin
                        a = vaddr_m;
                        v = vram_rd(a);
                        if (a >= ppurp_pkg::VPAL_BASE) begin
                            bus_latch_m = v;
                            read_buf_m = vram_rd(a - ppurp_pkg::VPAL_NT_OFS);
                        end else begin
                            bus_latch_m = read_buf_m;
                            read_buf_m = v;
                        end
                        step_vaddr();
                    end
                    default: ;
                endcase
            end
            ppurp_pkg::FN_WRITE: begin
                bus_latch_m = c.wdata;
                case (c.reg_sel)
                    ppurp_pkg::REG_CTRL: begin
                        was_en = ctrl_m[7];
                        ctrl_m = c.wdata;
                        temp_m = {temp_m[14:12], c.wdata[1:0], temp_m[9:0]};
                        outp = status_m[2] && c.wdata[7];
                        if (!nmi_prev_m && !was_en && outp) r.nmi_request = 1'b1;
                        nmi_prev_m = outp;
                    end
                    ppurp_pkg::REG_OAM_ADDR: oam_addr_m = c.wdata;
                    ppurp_pkg::REG_OAM_DATA: begin
                        spr_m[oam_addr_m] = c.wdata;
                        oam_addr_m = oam_addr_m + 8'd1;
                    end
                    ppurp_pkg::REG_SCROLL: begin
                        if (!toggle_m) begin
                            fine_x_m = c.wdata[2:0];
                            temp_m[4:0] = c.wdata[7:3];
                            toggle_m = 1'b1;
                        end else begin
                            temp_m = temp_m & 15'h0C1F;
                            temp_m[14:12] = c.wdata[2:0];
                            temp_m[9:5] = c.wdata[7:3];
                            toggle_m = 1'b0;
                        end
                    end
                    ppurp_pkg::REG_ADDR: begin
                        if (!toggle_m) begin
                            temp_m = {1'b0, c.wdata[5:0], temp_m[7:0]};
                            toggle_m = 1'b1;
                        end else begin
                            temp_m = {temp_m[14:8], c.wdata};
                            vaddr_m = temp_m[13:0];
                            toggle_m = 1'b0;
                        end
                    end
                    ppurp_pkg::REG_DATA: begin
                        vram_wr(vaddr_m, c.wdata);
                        step_vaddr();
                    end
                    default: ;
                endcase
            end
            ppurp_pkg::FN_VBLANK: begin
                if (!status_m[2] && ctrl_m[7]) r.nmi_request = 1'b1;
                status_m[2] = 1'b1;
            end
            ppurp_pkg::FN_PRERENDER: status_m = 3'b000;
            ppurp_pkg::FN_SPR0_HIT:  status_m[1] = 1'b1;
            ppurp_pkg::FN_SPR_OVF:   status_m[0] = 1'b1;
            default: ;
        endcase
        r.rdata = bus_latch_m;
    endtask

    // driver: next command goes out on the falling edge once the last one transferred
    always @(negedge i_clk) begin : drv
        t_ppu_cmd c;
        if (!(start && !cmd_taken)) begin
            if (cmd_pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                c = cmd_pending_q.pop_front();
                i_func    <= c.func;
                i_reg_req <= c.reg_sel;
                i_wdata   <= c.wdata;
                i_peek    <= c.peek;
                start     <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results are checked before the command transferred at the same edge is predicted
    always @(posedge i_clk) begin : mon
        t_ppu_cmd    c;
        t_ppu_result want;
        cmd_taken = 1'b0;
        if (!i_rst_n) begin
            mirror_m    = ppurp_pkg::MIR_VERT;
            vaddr_m     = '0;
            temp_m      = '0;
            fine_x_m    = '0;
            toggle_m    = 1'b0;
            ctrl_m      = '0;
            oam_addr_m  = '0;
            read_buf_m  = '0;
            bus_latch_m = '0;
            status_m    = '0;
            nmi_prev_m  = 1'b0;
            foreach (spr_m[i]) spr_m[i] = 8'hFF;
            foreach (pal_m[i]) pal_m[i] = 8'h00;
            foreach (nt_m[i])  nt_m[i]  = 8'h00;
            foreach (pat_m[i]) pat_m[i] = 8'h00;
        end else begin
            if (o_strobe) begin
                if (port_results_q.size() == 0) begin
                    $display("%0t: unexpected result, rdata %02h nmi_request %0b",
                             $time, o_rdata, o_nmi_request);
                    errors++;
                end else begin
                    want = port_results_q.pop_front();
                    if (o_rdata !== want.rdata) begin
                        $display("%0t: rdata mismatch, expected %02h, actual %02h",
                                 $time, want.rdata, o_rdata);
                        errors++;
                    end
                    if (o_nmi_request !== want.nmi_request) begin
                        $display("%0t: nmi_request mismatch, expected %0b, actual %0b",
                                 $time, want.nmi_request, o_nmi_request);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) mirror_m = i_cfg_data;
            if (start && !busy) begin
                c.func    = i_func;
                c.reg_sel = i_reg_req;
                c.wdata   = i_wdata;
                c.peek    = i_peek;
                ppu_port_access(c, want);
                port_results_q = {port_results_q, want};
                cmd_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_cmd(input logic [2:0] f, input logic [2:0] r,
                            input logic [7:0] d, input logic pk);
        t_ppu_cmd c;
        c.func    = f;
        c.reg_sel = r;
        c.wdata   = d;
        c.peek    = pk;
        cmd_pending_q = {cmd_pending_q, c};
        cmds_queued++;
    endtask

    function automatic logic [13:0] pick_vaddr();
        logic [13:0] a;
        case ($urandom_range(0, 5))
            0: a = 14'($urandom_range(0, 31));
            1: a = 14'($urandom);
            2, 3: begin
                a = 14'h2000 | 14'($urandom_range(0, 3) << 10) | 14'($urandom_range(0, 15));
                if ($urandom_range(0, 1)) a = a | 14'h1000;
            end
            4: a = ppurp_pkg::VPAL_BASE | 14'($urandom_range(0, 255));
            default: a = 14'h3FE0 | 14'($urandom_range(0, 31));
        endcase
        return a;
    endfunction

    // another address that may alias the same byte
    function automatic logic [13:0] alias_of(input logic [13:0] a);
        logic [13:0] b;
        b = a;
        if (a >= 14'h2000 && a < ppurp_pkg::VPAL_BASE) begin
            b = 14'h2000 | 14'($urandom_range(0, 3) << 10) | {4'b0, a[9:0]};
            if ($urandom_range(0, 1)) b = b | 14'h1000;
            if (b >= ppurp_pkg::VPAL_BASE) b = b & ~14'h1000;
        end else if (a >= ppurp_pkg::VPAL_BASE && $urandom_range(0, 1)) begin
            b = a ^ 14'h0010;
        end
        return b;
    endfunction

    task automatic push_vaddr(input logic [13:0] a);
        push_cmd(ppurp_pkg::FN_READ, ppurp_pkg::REG_STATUS, 8'($urandom), 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE, ppurp_pkg::REG_ADDR, {2'($urandom), a[13:8]},
                 1'($urandom));
        push_cmd(ppurp_pkg::FN_WRITE, ppurp_pkg::REG_ADDR, a[7:0], 1'($urandom));
    endtask

    task automatic push_seq();
        int          len;
        int          i;
        logic [13:0] a;
        case ($urandom_range(0, 11))
            0, 1, 2, 3: begin
                if ($urandom_range(0, 2) == 0)
                    push_cmd(ppurp_pkg::FN_WRITE, ppurp_pkg::REG_CTRL, 8'($urandom),
                             1'($urandom));
                a = pick_vaddr();
                len = $urandom_range(1, 6);
                push_vaddr(a);
                for (i = 0; i < len; i++)
                    push_cmd(ppurp_pkg::FN_WRITE, ppurp_pkg::REG_DATA, 8'($urandom),
                             1'($urandom));
                push_vaddr(alias_of(a));
                for (i = 0; i <= len; i++)
                    push_cmd(ppurp_pkg::FN_READ, ppurp_pkg::REG_DATA, 8'($urandom),
                             1'($urandom));
            end
            4, 5: begin
                push_vaddr(pick_vaddr());
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                    push_cmd($urandom_range(0, 9) < 6 ? ppurp_pkg::FN_WRITE
                                                      : ppurp_pkg::FN_READ,
                             ppurp_pkg::REG_DATA, 8'($urandom), 1'($urandom));
            end
            6: begin
                push_cmd(ppurp_pkg::FN_WRITE, ppurp_pkg::REG_OAM_ADDR, 8'($urandom),
                         1'($urandom));
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                    push_cmd($urandom_range(0, 1) ? ppurp_pkg::FN_WRITE : ppurp_pkg::FN_READ,
                             ppurp_pkg::REG_OAM_DATA, 8'($urandom), 1'($urandom));
            end
            7: begin
                push_cmd(ppurp_pkg::FN_READ, ppurp_pkg::REG_STATUS, 8'($urandom), 1'b0);
                push_cmd(ppurp_pkg::FN_WRITE, ppurp_pkg::REG_SCROLL, 8'($urandom),
                         1'($urandom));
                push_cmd(ppurp_pkg::FN_WRITE, ppurp_pkg::REG_SCROLL, 8'($urandom),
                         1'($urandom));
            end
            8: push_cmd(ppurp_pkg::FN_WRITE, ppurp_pkg::REG_CTRL, 8'($urandom), 1'($urandom));
            9: begin
                push_cmd(3'($urandom_range(ppurp_pkg::FN_VBLANK, ppurp_pkg::FN_SPR_OVF)),
                         3'($urandom), 8'($urandom), 1'($urandom));
                if ($urandom_range(0, 1))
                    push_cmd(ppurp_pkg::FN_READ, ppurp_pkg::REG_STATUS, 8'($urandom),
                             1'($urandom));
            end
            default: begin
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++)
                    push_cmd(3'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
            end
        endcase
    endtask

    task automatic wait_port_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (cmd_pending_q.size() != 0 || start || port_results_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_mirror(input logic [2:0] mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [2:0] mirror_plan [8];
        int         gap_plan [3];
        int         p;
        int         target;
        mirror_plan = '{ppurp_pkg::MIR_LOW, ppurp_pkg::MIR_HIGH, ppurp_pkg::MIR_FOUR,
                        MIR_SPARE5, MIR_SPARE7, MIR_SPARE6,
                        ppurp_pkg::MIR_VERT, ppurp_pkg::MIR_HORZ};
        gap_plan    = '{0, 79, 7};
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = ppurp_pkg::MIR_VERT;
        cmds_queued = 0;
        gap_pct     = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        program_mirror(ppurp_pkg::MIR_HORZ);

        // NMI enable against vblank, status flags, peek
        push_cmd(ppurp_pkg::FN_READ,      ppurp_pkg::REG_STATUS,   8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_CTRL,     8'h80, 1'b0);
        push_cmd(ppurp_pkg::FN_VBLANK,    ppurp_pkg::REG_CTRL,     8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_VBLANK,    ppurp_pkg::REG_CTRL,     8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_READ,      ppurp_pkg::REG_STATUS,   8'h00, 1'b1);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_CTRL,     8'h80, 1'b0);
        push_cmd(ppurp_pkg::FN_READ,      ppurp_pkg::REG_STATUS,   8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_CTRL,     8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_VBLANK,    ppurp_pkg::REG_CTRL,     8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_CTRL,     8'h84, 1'b0);
        push_cmd(ppurp_pkg::FN_SPR0_HIT,  ppurp_pkg::REG_CTRL,     8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_SPR_OVF,   ppurp_pkg::REG_CTRL,     8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_READ,      ppurp_pkg::REG_STATUS,   8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_PRERENDER, ppurp_pkg::REG_CTRL,     8'h00, 1'b0);
        // sprite address wrap, read without increment
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_OAM_ADDR, 8'hFF, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_OAM_DATA, 8'hA5, 1'b0);
        push_cmd(ppurp_pkg::FN_READ,      ppurp_pkg::REG_OAM_DATA, 8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_SCROLL,   8'hFF, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_SCROLL,   8'h00, 1'b0);
        // palette alias, stride-32 VRAM wrap, direct palette read
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_ADDR,     8'hFF, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_ADDR,     8'hF0, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_DATA,     8'h5A, 1'b1);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_ADDR,     8'h3F, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_ADDR,     8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_READ,      ppurp_pkg::REG_DATA,     8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_READ,      ppurp_pkg::REG_MASK,     8'h00, 1'b0);
        push_cmd(ppurp_pkg::FN_WRITE,     ppurp_pkg::REG_STATUS,   8'hFF, 1'b0);
        push_cmd(FN_SPARE6,               ppurp_pkg::REG_DATA,     8'hFF, 1'b1);
        push_cmd(FN_SPARE7,               ppurp_pkg::REG_CTRL,     8'h00, 1'b0);

        for (p = 0; p < 8; p++) begin
            wait_port_idle();
            program_mirror(mirror_plan[p]);
            gap_pct = gap_plan[p % 3];
            target = cmds_queued + PHASE_ITEMS / 2;
            while (cmds_queued < target) push_seq();
            wait_port_idle();
            target = cmds_queued + PHASE_ITEMS / 2;
            while (cmds_queued < target) push_seq();
        end
        wait_port_idle();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
